/* rtl/cch_pkg.sv */
// shared types, constants and the arctangent table of the compass block
`default_nettype none

package cch_pkg;

  // sample width and derived datapath widths
  localparam int AXIS_BITS  = 16;
  localparam int AW         = AXIS_BITS + 2;   // centred value and range operands
  localparam int PW         = 2 * AW;          // cross products
  localparam int CW         = PW + 2;          // vector with headroom for cordic gain
  localparam int ZW         = 40;              // angle in units of 1e-9 degree
  localparam int DEG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 2'd2;

  // sensor status bit positions
  localparam int ST_NEW  = 0;
  localparam int ST_OVF  = 1;
  localparam int ST_SKIP = 2;

  // result codes
  localparam logic [2:0] RC_HEADING   = 3'd0;
  localparam logic [2:0] RC_OVERFLOW  = 3'd1;
  localparam logic [2:0] RC_SKIPPED   = 3'd2;
  localparam logic [2:0] RC_NO_DATA   = 3'd3;
  localparam logic [2:0] RC_GATHERED  = 3'd4;
  localparam logic [2:0] RC_CAL_DONE  = 3'd5;
  localparam logic [2:0] RC_CAL_IDLE  = 3'd6;
  localparam logic [2:0] RC_BAD_RANGE = 3'd7;

  // calibration run status
  localparam logic [1:0] CAL_RUNNING = 2'd0;
  localparam logic [1:0] CAL_DONE    = 2'd1;
  localparam logic [1:0] CAL_FAILED  = 2'd2;

  // reset values
  localparam logic signed [AXIS_BITS-1:0] EXT_LOW_RST  = {1'b0, {(AXIS_BITS-1){1'b1}}};
  localparam logic signed [AXIS_BITS-1:0] EXT_HIGH_RST = {1'b1, {(AXIS_BITS-1){1'b0}}};
  localparam logic [CFG_DATA_W-1:0]       CAL_SAMPLES_RST = 16'd500;

  // angle constants in 1e-9 degree
  localparam logic signed [ZW-1:0] DEG_UNIT = 40'sd1000000000;
  localparam logic signed [ZW-1:0] ANG_90   = 40'sd90000000000;
  localparam logic signed [ZW-1:0] ANG_180  = 40'sd180000000000;
  localparam logic signed [ZW-1:0] ANG_360  = 40'sd360000000000;

  // whole degrees: 1e9 is 2^9 * 5^9, so drop 9 bits, then multiply by
  // ceil(2^51 / 5^9) and keep the bits above 51; exact up to 360 degrees
  localparam int          DEG_SHIFT = 9;
  localparam int          RECIP_SH  = 51;
  localparam logic [30:0] DEG_RECIP = 31'd1152921505;

  typedef struct packed {
    logic [2:0]                  sensor_status;
    logic signed [AXIS_BITS-1:0] axis_x;
    logic signed [AXIS_BITS-1:0] axis_y;
    logic signed [AXIS_BITS-1:0] axis_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                  result_code;
    logic [DEG_W-1:0]            heading_degrees;
    logic signed [AXIS_BITS-1:0] first_axis_min;
    logic signed [AXIS_BITS-1:0] first_axis_max;
    logic signed [AXIS_BITS-1:0] second_axis_min;
    logic signed [AXIS_BITS-1:0] second_axis_max;
  } out_item_t;

  // calibration extents
  typedef struct packed {
    logic signed [AXIS_BITS-1:0] first_low;
    logic signed [AXIS_BITS-1:0] first_high;
    logic signed [AXIS_BITS-1:0] second_low;
    logic signed [AXIS_BITS-1:0] second_high;
  } ext_t;

  // outcome of one reading
  typedef struct packed {
    logic [2:0] code;
    logic       heading_req;
  } cal_resp_t;

  // centred values and ranges for the heading cross products
  typedef struct packed {
    logic signed [AW-1:0] a_first;
    logic signed [AW-1:0] a_second;
    logic signed [AW-1:0] b_first;
    logic signed [AW-1:0] b_second;
  } hop_t;

  // rounded atan(2^-i) in 1e-9 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 40'sd45000000000;
      5'd1:  v = 40'sd26565051177;
      5'd2:  v = 40'sd14036243468;
      5'd3:  v = 40'sd7125016349;
      5'd4:  v = 40'sd3576334375;
      5'd5:  v = 40'sd1789910608;
      5'd6:  v = 40'sd895173710;
      5'd7:  v = 40'sd447614171;
      5'd8:  v = 40'sd223810500;
      5'd9:  v = 40'sd111905677;
      5'd10: v = 40'sd55952892;
      5'd11: v = 40'sd27976453;
      5'd12: v = 40'sd13988227;
      5'd13: v = 40'sd6994114;
      5'd14: v = 40'sd3497057;
      5'd15: v = 40'sd1748528;
      5'd16: v = 40'sd874264;
      5'd17: v = 40'sd437132;
      5'd18: v = 40'sd218566;
      5'd19: v = 40'sd109283;
      5'd20: v = 40'sd54642;
      5'd21: v = 40'sd27321;
      5'd22: v = 40'sd13660;
      5'd23: v = 40'sd6830;
      5'd24: v = 40'sd3415;
      5'd25: v = 40'sd1708;
      5'd26: v = 40'sd854;
      5'd27: v = 40'sd427;
      5'd28: v = 40'sd213;
      5'd29: v = 40'sd107;
      5'd30: v = 40'sd53;
      5'd31: v = 40'sd27;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/cch_cal.sv */
// configuration registers, calibration extents and per-reading decision
`default_nettype none

module cch_cal (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cch_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             step,
  input  cch_pkg::in_item_t                item,
  output cch_pkg::cal_resp_t               resp,
  output cch_pkg::hop_t                    hop,
  output cch_pkg::ext_t                    ext
);

  import cch_pkg::*;

  logic                  mode_r, mode_nxt;
  logic                  plane_r, plane_nxt;
  logic [CFG_DATA_W-1:0] cal_samples_r, cal_samples_nxt;
  ext_t                  ext_r, ext_nxt;
  logic [CFG_DATA_W-1:0] samples_r, samples_nxt;
  logic [1:0]            status_r, status_nxt;

  logic signed [AXIS_BITS-1:0] v1, vy;
  logic signed [AW-1:0]        v1_e, vy_e, fl_e, fh_e, sl_e, sh_e;
  logic [CFG_DATA_W-1:0]       samples_inc;
  logic                        ovf, skip, fresh;

  assign v1    = plane_r ? item.axis_z : item.axis_x;
  assign vy    = item.axis_y;
  assign ovf   = item.sensor_status[ST_OVF];
  assign skip  = item.sensor_status[ST_SKIP];
  assign fresh = item.sensor_status[ST_NEW];

  // saturating sample count
  assign samples_inc = (samples_r != '1) ? samples_r + 1'b1 : samples_r;

  // centred values and ranges for the heading path
  assign v1_e = AW'(v1);
  assign vy_e = AW'(vy);
  assign fl_e = AW'(ext_r.first_low);
  assign fh_e = AW'(ext_r.first_high);
  assign sl_e = AW'(ext_r.second_low);
  assign sh_e = AW'(ext_r.second_high);

  assign hop.a_first  = (v1_e <<< 1) - fh_e - fl_e;
  assign hop.a_second = (vy_e <<< 1) - sh_e - sl_e;
  assign hop.b_first  = fh_e - fl_e;
  assign hop.b_second = sh_e - sl_e;

  assign ext = ext_r;

  // next state from a config write or a reading
  always_comb begin
    mode_nxt         = mode_r;
    plane_nxt        = plane_r;
    cal_samples_nxt  = cal_samples_r;
    ext_nxt          = ext_r;
    samples_nxt      = samples_r;
    status_nxt       = status_r;
    resp.code        = RC_NO_DATA;
    resp.heading_req = 1'b0;

    if (mode_r) begin
      if (status_r != CAL_RUNNING) begin
        resp.code = RC_CAL_IDLE;
      end else if (ovf) begin
        status_nxt = CAL_FAILED;
        resp.code  = RC_CAL_IDLE;
      end else if (skip) begin
        resp.code = RC_SKIPPED;
      end else if (fresh) begin
        if (v1 < ext_r.first_low)   ext_nxt.first_low   = v1;
        if (v1 > ext_r.first_high)  ext_nxt.first_high  = v1;
        if (vy < ext_r.second_low)  ext_nxt.second_low  = vy;
        if (vy > ext_r.second_high) ext_nxt.second_high = vy;
        samples_nxt = samples_inc;
        if (samples_inc >= cal_samples_r) begin
          status_nxt = CAL_DONE;
          resp.code  = RC_CAL_DONE;
        end else begin
          resp.code = RC_GATHERED;
        end
      end else begin
        resp.code = RC_NO_DATA;
      end
    end else begin
      if (ovf) begin
        resp.code = RC_OVERFLOW;
      end else if (skip) begin
        resp.code = RC_SKIPPED;
      end else if (!fresh) begin
        resp.code = RC_NO_DATA;
      end else if (ext_r.first_high <= ext_r.first_low ||
                   ext_r.second_high <= ext_r.second_low) begin
        resp.code = RC_BAD_RANGE;
      end else begin
        resp.code        = RC_HEADING;
        resp.heading_req = 1'b1;
      end
    end

    // a reading only commits its changes when accepted
    if (!step) begin
      ext_nxt     = ext_r;
      samples_nxt = samples_r;
      status_nxt  = status_r;
    end

    if (cfg_we) begin
      ext_nxt     = ext_r;
      samples_nxt = samples_r;
      status_nxt  = status_r;
      unique case (cfg_index)
        CFG_MODE: begin
          mode_nxt    = cfg_wdata[0];
          samples_nxt = '0;
          if (cfg_wdata[0]) begin
            ext_nxt.first_low   = EXT_LOW_RST;
            ext_nxt.first_high  = EXT_HIGH_RST;
            ext_nxt.second_low  = EXT_LOW_RST;
            ext_nxt.second_high = EXT_HIGH_RST;
            status_nxt          = CAL_RUNNING;
          end
        end
        CFG_PLANE:       plane_nxt       = cfg_wdata[0];
        CFG_CAL_SAMPLES: cal_samples_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r             <= 1'b0;
      plane_r            <= 1'b0;
      cal_samples_r      <= CAL_SAMPLES_RST;
      ext_r.first_low    <= EXT_LOW_RST;
      ext_r.first_high   <= EXT_HIGH_RST;
      ext_r.second_low   <= EXT_LOW_RST;
      ext_r.second_high  <= EXT_HIGH_RST;
      samples_r          <= '0;
      status_r           <= CAL_RUNNING;
    end else begin
      mode_r        <= mode_nxt;
      plane_r       <= plane_nxt;
      cal_samples_r <= cal_samples_nxt;
      ext_r         <= ext_nxt;
      samples_r     <= samples_nxt;
      status_r      <= status_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/cch_cordic.sv */
// iterative cordic vectoring unit with truncating conversion to whole degrees
`default_nettype none

module cch_cordic #(
  parameter int ANGLE_STEPS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [cch_pkg::PW-1:0]     x_in,
  input  logic signed [cch_pkg::PW-1:0]     y_in,
  output logic                              done,
  output logic [cch_pkg::DEG_W-1:0]         deg
);

  import cch_pkg::*;

  localparam int STEP_W = $clog2(ANGLE_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ANGLE_STEPS - 1);
  localparam int NW = ZW - 1 - DEG_SHIFT;
  localparam int QW = NW + $bits(DEG_RECIP);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_ITER = 2'd1;
  localparam logic [1:0] C_FOLD = 2'd2;
  localparam logic [1:0] C_DIV  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic signed [CW-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]    z_r, z_nxt;
  logic [STEP_W-1:0]       i_r, i_nxt;
  logic [DEG_W-1:0]        q_r, q_nxt;
  logic                    done_r, done_nxt;

  logic signed [CW-1:0]    x_e, y_e, dx, dy;
  logic signed [ZW-1:0]    ang;
  logic                    y_pos;
  logic [QW-1:0]           qprod;

  assign x_e   = CW'(x_in);
  assign y_e   = CW'(y_in);
  assign dx    = y_r >>> i_r;
  assign dy    = x_r >>> i_r;
  assign ang   = atan_lut(5'(i_r));
  assign y_pos = !y_r[CW-1] && (y_r != '0);
  // folded angle is positive, so its low bits above the shift are the value
  assign qprod = QW'(z_r[ZW-2:DEG_SHIFT]) * QW'(DEG_RECIP);

  assign done = done_r;
  assign deg  = q_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    i_nxt     = i_r;
    q_nxt     = q_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          x_nxt = x_e;
          y_nxt = y_e;
          i_nxt = '0;
          q_nxt = '0;
          // exact axes skip the iteration
          if (y_in == '0) begin
            z_nxt     = x_in[PW-1] ? ANG_180 : '0;
            state_nxt = C_FOLD;
          end else if (x_in == '0) begin
            z_nxt     = y_in[PW-1] ? -ANG_90 : ANG_90;
            state_nxt = C_FOLD;
          end else if (x_in[PW-1]) begin
            // left half plane: rotate by half a turn first
            x_nxt     = -x_e;
            y_nxt     = -y_e;
            z_nxt     = ANG_180;
            state_nxt = C_ITER;
          end else begin
            z_nxt     = '0;
            state_nxt = C_ITER;
          end
        end
      end
      C_ITER: begin
        if (y_pos) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + ang;
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - ang;
        end
        if (i_r == LAST_STEP) begin
          state_nxt = C_FOLD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      C_FOLD: begin
        // angle stays within (-180,280) degrees, so one wrap into (0,360]
        if (z_r[ZW-1] || z_r == '0) begin
          z_nxt = z_r + ANG_360;
        end
        state_nxt = C_DIV;
      end
      C_DIV: begin
        // whole degrees by reciprocal multiplication
        q_nxt     = qprod[RECIP_SH +: DEG_W];
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    q_r <= q_nxt;
  end

endmodule

`default_nettype wire

/* rtl/compass_calibrate_and_heading.sv */
// top level: item sequencer, shared cross-product multiplier and result register
// A heading passes from acceptance through the two multiplier states, the cordic loop,
// fold and divide to out_valid; exact axes skip the cordic loop.
// Every other result code goes from acceptance straight to the output state, then to out_valid.
// The block takes one item at a time; in_ready is high only between items and waits while
// a result is held.
// Reset (rst_n, synchronous): mode 0, plane 0, cal_samples 500, extents empty,
// calibration running, no result pending.
`default_nettype none

module compass_calibrate_and_heading #(
  parameter int ANGLE_STEPS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cch_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cch_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [cch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cch_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import cch_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_MUL2  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]           state_r, state_nxt;
  hop_t                 hop_r, hop_nxt;
  logic [2:0]           code_r, code_nxt;
  logic [DEG_W-1:0]     deg_r, deg_nxt;
  logic signed [PW-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 accept, load_out, cor_start, cor_done;
  logic [DEG_W-1:0]     cor_deg;
  cal_resp_t            resp;
  hop_t                 hop;
  ext_t                 ext;
  logic signed [AW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cor_start = (state_r == S_START);
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // calibration state and decision
  cch_cal u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (accept),
    .item      (in_data),
    .resp      (resp),
    .hop       (hop),
    .ext       (ext)
  );

  // shared multiplier: first cross product, then second
  assign mul_a = (state_r == S_MUL2) ? hop_r.a_second : hop_r.a_first;
  assign mul_b = (state_r == S_MUL2) ? hop_r.b_first  : hop_r.b_second;
  assign prod  = mul_a * mul_b;

  // angle unit
  cch_cordic #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (p1_r),
    .y_in  (p2_r),
    .done  (cor_done),
    .deg   (cor_deg)
  );

  // item sequencer
  always_comb begin
    state_nxt = state_r;
    hop_nxt   = hop_r;
    code_nxt  = code_r;
    deg_nxt   = deg_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          hop_nxt   = hop;
          code_nxt  = resp.code;
          deg_nxt   = '0;
          state_nxt = resp.heading_req ? S_MUL1 : S_OUT;
        end
      end
      S_MUL1: begin
        p1_nxt    = prod;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        p2_nxt    = prod;
        state_nxt = S_START;
      end
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (cor_done) begin
          deg_nxt   = cor_deg;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.result_code     = code_r;
      out_data_nxt.heading_degrees = deg_r;
      out_data_nxt.first_axis_min  = ext.first_low;
      out_data_nxt.first_axis_max  = ext.first_high;
      out_data_nxt.second_axis_min = ext.second_low;
      out_data_nxt.second_axis_max = ext.second_high;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hop_r      <= hop_nxt;
    code_r     <= code_nxt;
    deg_r      <= deg_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* verif/compass_calibrate_and_heading_tb.sv */
// self-checking testbench for the compass calibration and heading block
`timescale 1ns / 100ps

module compass_calibrate_and_heading_tb;
  import cch_pkg::*;

  localparam int          CORDIC_STEPS   = 20;
  localparam int          CYCLE_LIMIT    = 600000;
  localparam int          RANDOM_READS   = 650;
  localparam logic [15:0] CAL_TARGET_RST = 16'd500;
  localparam longint      DEG            = 64'sd1000000000;

  // status patterns of one reading
  localparam logic [2:0] S_NONE = 3'b000;
  localparam logic [2:0] S_NEW  = 3'b001 << ST_NEW;
  localparam logic [2:0] S_OVF  = 3'b001 << ST_OVF;
  localparam logic [2:0] S_SKIP = 3'b001 << ST_SKIP;

  // index past the last register, written to show it is ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // atan(2^-i) in 1e-9 degree, rounded
  localparam longint ARC_TAB [0:19] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375,  64'sd1789910608,  64'sd895173710,   64'sd447614171,
    64'sd223810500,   64'sd111905677,   64'sd55952892,    64'sd27976453,
    64'sd13988227,    64'sd6994114,     64'sd3497057,     64'sd1748528,
    64'sd874264,      64'sd437132,      64'sd218566,      64'sd109283
  };

  // expected reports of the compass, worked out per accepted reading
  class compass_scoreboard;
    bit          mode_cal;
    bit          plane_zy;
    logic [15:0] target;
    longint      first_lo, first_hi, second_lo, second_hi;
    int unsigned taken;
    logic [1:0]  cal_state;
    out_item_t   expected_reports[$];
    int          n_errors;
    int          n_checked;
    int          code_hits[8];

    function new();
      mode_cal  = 1'b0;
      plane_zy  = 1'b0;
      target    = CAL_TARGET_RST;
      clear_extents();
      taken     = 0;
      cal_state = CAL_RUNNING;
      n_errors  = 0;
      n_checked = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
    endfunction

    function void clear_extents();
      first_lo  = 32767;
      second_lo = 32767;
      first_hi  = -32768;
      second_hi = -32768;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE: begin
          mode_cal = val[0];
          taken    = 0;
          if (mode_cal) begin
            clear_extents();
            cal_state = CAL_RUNNING;
          end
        end
        CFG_PLANE:       plane_zy = val[0];
        CFG_CAL_SAMPLES: target   = val;
        default: ;
      endcase
    endfunction

    // cordic vectoring angle of (x, y), folded into (-180, 180]
    function longint vector_angle(longint x, longint y);
      longint base, z, dx, dy;
      int     i;
      base = 0;
      z    = 0;
      if (y == 0) return (x < 0) ? 180 * DEG : 0;
      if (x == 0) return (y > 0) ? 90 * DEG : -90 * DEG;
      if (x < 0) begin
        x    = -x;
        y    = -y;
        base = 180 * DEG;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ARC_TAB[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ARC_TAB[i];
        end
      end
      z = z + base;
      if (z > 180 * DEG) z = z - 360 * DEG;
      return z;
    endfunction

    // one accepted reading: update state, queue the report it should give
    function void note_reading(in_item_t r);
      out_item_t  w;
      longint     v1, vy, a1, a2, b1, b2, z;
      logic [2:0] st;
      st = r.sensor_status;
      v1 = plane_zy ? longint'(r.axis_z) : longint'(r.axis_x);
      vy = longint'(r.axis_y);
      w  = '0;
      if (mode_cal) begin
        if (cal_state != CAL_RUNNING) begin
          w.result_code = RC_CAL_IDLE;
        end else if (st[ST_OVF]) begin
          cal_state     = CAL_FAILED;
          w.result_code = RC_CAL_IDLE;
        end else if (st[ST_SKIP]) begin
          w.result_code = RC_SKIPPED;
        end else if (st[ST_NEW]) begin
          if (v1 < first_lo)  first_lo  = v1;
          if (v1 > first_hi)  first_hi  = v1;
          if (vy < second_lo) second_lo = vy;
          if (vy > second_hi) second_hi = vy;
          if (taken < 32'hFFFF) taken++;
          if (taken >= target) begin
            cal_state     = CAL_DONE;
            w.result_code = RC_CAL_DONE;
          end else begin
            w.result_code = RC_GATHERED;
          end
        end else begin
          w.result_code = RC_NO_DATA;
        end
      end else begin
        if (st[ST_OVF]) begin
          w.result_code = RC_OVERFLOW;
        end else if (st[ST_SKIP]) begin
          w.result_code = RC_SKIPPED;
        end else if (!st[ST_NEW]) begin
          w.result_code = RC_NO_DATA;
        end else if (first_hi <= first_lo || second_hi <= second_lo) begin
          w.result_code = RC_BAD_RANGE;
        end else begin
          // centred over range, compared by cross products
          a1 = 2 * v1 - first_hi - first_lo;
          a2 = 2 * vy - second_hi - second_lo;
          b1 = first_hi - first_lo;
          b2 = second_hi - second_lo;
          z  = vector_angle(a1 * b2, a2 * b1);
          if (z <= 0) z = z + 360 * DEG;
          w.result_code     = RC_HEADING;
          w.heading_degrees = 9'(z / DEG);
        end
      end
      w.first_axis_min  = 16'(first_lo);
      w.first_axis_max  = 16'(first_hi);
      w.second_axis_min = 16'(second_lo);
      w.second_axis_max = 16'(second_hi);
      expected_reports.push_back(w);
    endfunction

    // one result beat against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        n_errors++;
        $error("result beat with no reading outstanding: %h", got);
        return;
      end
      want = expected_reports.pop_front();
      n_checked++;
      code_hits[want.result_code]++;
      if (got.result_code !== want.result_code) begin
        n_errors++;
        $error("result_code: expected %0d, got %0d", want.result_code, got.result_code);
      end
      if (got.heading_degrees !== want.heading_degrees) begin
        n_errors++;
        $error("heading_degrees: expected %0d, got %0d",
               want.heading_degrees, got.heading_degrees);
      end
      if (got.first_axis_min !== want.first_axis_min) begin
        n_errors++;
        $error("first_axis_min: expected %0d, got %0d",
               want.first_axis_min, got.first_axis_min);
      end
      if (got.first_axis_max !== want.first_axis_max) begin
        n_errors++;
        $error("first_axis_max: expected %0d, got %0d",
               want.first_axis_max, got.first_axis_max);
      end
      if (got.second_axis_min !== want.second_axis_min) begin
        n_errors++;
        $error("second_axis_min: expected %0d, got %0d",
               want.second_axis_min, got.second_axis_min);
      end
      if (got.second_axis_max !== want.second_axis_max) begin
        n_errors++;
        $error("second_axis_max: expected %0d, got %0d",
               want.second_axis_max, got.second_axis_max);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  compass_scoreboard sb;
  int   n_sent      = 0;
  int   cycle_count = 0;
  int   hold_left   = 0;
  bit   hold_done   = 1'b0;
  logic pressure_go;
  logic steady;

  compass_calibrate_and_heading dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("compass_calibrate_and_heading_tb: done, errors");
      $finish;
    end
  end

  // result side: check each beat, stall at random, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (pressure_go && !hold_done) begin
        hold_left <= 300;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  function automatic in_item_t reading(logic [2:0] st, int x, int y, int z);
    in_item_t r;
    r.sensor_status = st;
    r.axis_x        = 16'(x);
    r.axis_y        = 16'(y);
    r.axis_z        = 16'(z);
    return r;
  endfunction

  // value within w of c, clamped to the sample range
  function automatic logic signed [15:0] near(longint c, longint w);
    longint v;
    v = c + longint'($urandom_range(32'(2 * w))) - w;
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic in_item_t cal_sample(longint cx, longint cy, longint cz, longint w);
    in_item_t r;
    int       p;
    r.axis_x = near(cx, w);
    r.axis_y = near(cy, w);
    r.axis_z = near(cz, w);
    p = $urandom_range(99);
    if (p < 90) begin
      r.sensor_status = S_NEW;
    end else if (p < 96) begin
      case ($urandom_range(2))
        0:       r.sensor_status = S_NONE;
        1:       r.sensor_status = S_SKIP;
        default: r.sensor_status = S_SKIP | S_NEW;
      endcase
    end else begin
      r.sensor_status = 3'($urandom_range(7));
    end
    return r;
  endfunction

  // heading reading, mostly inside the calibrated window
  function automatic in_item_t heading_sample();
    in_item_t             r;
    longint               c1, c2, w1, w2;
    logic signed [15:0]   v1;
    r.sensor_status = ($urandom_range(99) < 80) ? S_NEW : 3'($urandom_range(7));
    r.axis_x        = 16'($urandom);
    r.axis_y        = 16'($urandom);
    r.axis_z        = 16'($urandom);
    if ($urandom_range(99) < 70 && sb.first_hi > sb.first_lo
        && sb.second_hi > sb.second_lo) begin
      c1 = (sb.first_hi + sb.first_lo) >>> 1;
      c2 = (sb.second_hi + sb.second_lo) >>> 1;
      w1 = ((sb.first_hi - sb.first_lo) >>> 1) + 4;
      w2 = ((sb.second_hi - sb.second_lo) >>> 1) + 4;
      v1       = near(c1, w1);
      r.axis_y = near(c2, w2);
      // land on an axis now and then
      if ($urandom_range(19) == 0) v1 = 16'(c1);
      else if ($urandom_range(19) == 0) r.axis_y = 16'(c2);
      if (sb.plane_zy) r.axis_z = v1;
      else r.axis_x = v1;
    end
    return r;
  endfunction

  // offer one beat, wait for it to be taken
  task automatic send_reading(in_item_t r);
    steady <= (n_sent >= 420 && n_sent < 540);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_reading(r);
    n_sent++;
  endtask

  // stop offering and let every outstanding report come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.apply_write(idx, val);
    @(posedge clk);
  endtask

  initial begin
    int          rounds;
    int          len;
    int          k;
    logic [15:0] target;
    longint      cx, cy, cz, w;

    sb          = new();
    rounds      = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    pressure_go <= 1'b0;
    steady      <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty extents after reset, and the status priority in heading mode
    send_reading(reading(S_NEW, 0, 0, 0));
    send_reading(reading(S_OVF, 1, 2, 3));
    send_reading(reading(S_SKIP, 1, 2, 3));
    send_reading(reading(S_NONE, 1, 2, 3));
    send_reading(reading(S_OVF | S_SKIP | S_NEW, 1, 2, 3));
    send_reading(reading(S_SKIP | S_NEW, 1, 2, 3));
    drain();

    // short x-y calibration run, then readings after it is done
    cfg_write(CFG_PLANE, 16'd0);
    cfg_write(CFG_CAL_SAMPLES, 16'd4);
    cfg_write(CFG_MODE, 16'd1);
    send_reading(reading(S_NEW, -1000, -1000, 5));
    send_reading(reading(S_NEW, 1000, 1000, -5));
    send_reading(reading(S_NONE, 9, 9, 9));
    send_reading(reading(S_SKIP | S_NEW, 9, 9, 9));
    send_reading(reading(S_NEW, 0, 0, 0));
    send_reading(reading(S_NEW, 200, -200, 0));
    send_reading(reading(S_NEW, 32767, -32768, 0));
    drain();

    // exact axes and extreme inputs
    cfg_write(CFG_MODE, 16'd0);
    send_reading(reading(S_NEW, 0, 0, 0));
    send_reading(reading(S_NEW, 500, 0, 0));
    send_reading(reading(S_NEW, -500, 0, 0));
    send_reading(reading(S_NEW, 0, 500, 0));
    send_reading(reading(S_NEW, 0, -500, 0));
    send_reading(reading(S_NEW, -32768, 32767, 0));
    send_reading(reading(S_NEW, 32767, -32768, 0));
    drain();

    // zero sample target in the z-y plane
    cfg_write(CFG_PLANE, 16'd1);
    cfg_write(CFG_CAL_SAMPLES, 16'd0);
    cfg_write(CFG_MODE, 16'd1);
    send_reading(reading(S_NEW, 123, 32767, -32768));
    send_reading(reading(S_NEW, 5, 5, 5));
    drain();

    // overflow in the middle of a run
    cfg_write(CFG_CAL_SAMPLES, 16'd3);
    cfg_write(CFG_MODE, 16'd1);
    send_reading(reading(S_NEW, 10, 20, 30));
    send_reading(reading(S_OVF | S_NEW, 10, 20, 30));
    send_reading(reading(S_NEW, 10, 20, 30));
    drain();

    // target lowered below the count mid-run; the spare index does nothing
    cfg_write(CFG_CAL_SAMPLES, 16'd10);
    cfg_write(CFG_MODE, 16'd1);
    send_reading(reading(S_NEW, 0, -300, -400));
    send_reading(reading(S_NEW, 0, 300, 400));
    send_reading(reading(S_NEW, 0, 10, 10));
    drain();
    cfg_write(CFG_CAL_SAMPLES, 16'd2);
    cfg_write(CFG_SPARE, 16'hFFFF);
    send_reading(reading(S_NEW, 0, 0, 0));
    drain();
    cfg_write(CFG_MODE, 16'd0);
    send_reading(reading(S_NEW, -7, 150, 150));
    send_reading(reading(S_NEW, 7, -150, -399));
    drain();

    // random rounds: calibrate with random content, then take headings
    k = n_sent;
    while (n_sent < k + RANDOM_READS) begin
      rounds++;
      if (n_sent >= k + 200) pressure_go <= 1'b1;
      cfg_write(CFG_PLANE, 16'($urandom_range(1)));
      if ($urandom_range(5) != 0) begin
        case ($urandom_range(9))
          0:       target = 16'd1;
          1:       target = 16'hFFFF;
          2:       target = 16'd0;
          default: target = 16'($urandom_range(2, 40));
        endcase
        cfg_write(CFG_CAL_SAMPLES, target);
        cfg_write(CFG_MODE, 16'd1);
        cx = longint'($urandom_range(65535)) - 32768;
        cy = longint'($urandom_range(65535)) - 32768;
        cz = longint'($urandom_range(65535)) - 32768;
        case ($urandom_range(3))
          0:       w = 32768;
          1:       w = $urandom_range(1, 64);
          default: w = $urandom_range(64, 4000);
        endcase
        if (target == 16'hFFFF) len = $urandom_range(20, 60);
        else len = int'(target) + $urandom_range(0, 3);
        if (target > 4 && target != 16'hFFFF && $urandom_range(4) == 0) begin
          // lower the target part way through
          repeat (int'(target) / 2) send_reading(cal_sample(cx, cy, cz, w));
          drain();
          cfg_write(CFG_CAL_SAMPLES, 16'($urandom_range(1, int'(target) / 2)));
          len = 3;
        end
        repeat (len) send_reading(cal_sample(cx, cy, cz, w));
        drain();
        if ($urandom_range(3) == 0) cfg_write(CFG_PLANE, 16'($urandom_range(1)));
      end
      cfg_write(CFG_MODE, 16'd0);
      repeat ($urandom_range(15, 40)) send_reading(heading_sample());
      drain();
    end

    repeat (60) @(posedge clk);
    $display("run covered %0d readings in %0d random rounds, %0d reports checked",
             n_sent, rounds, sb.n_checked);
    $display("codes: heading %0d ovf %0d skip %0d none %0d gathered %0d done %0d idle %0d range %0d",
             sb.code_hits[RC_HEADING], sb.code_hits[RC_OVERFLOW], sb.code_hits[RC_SKIPPED],
             sb.code_hits[RC_NO_DATA], sb.code_hits[RC_GATHERED], sb.code_hits[RC_CAL_DONE],
             sb.code_hits[RC_CAL_IDLE], sb.code_hits[RC_BAD_RANGE]);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("compass_calibrate_and_heading_tb: done, clean");
    end else begin
      $display("compass_calibrate_and_heading_tb: done, errors");
    end
    $finish;
  end

endmodule
